FILE: hw/rtl/orab_pkg.sv
// Shared widths, codes and control types for the OFDMA random-access backoff unit.
package orab_pkg;

	localparam int WIN_W  = 10;
	localparam int UNIT_W = 7;
	localparam int FUNC_W = 2;
	localparam int CAT_W  = 2;
	localparam int REM_W  = WIN_W + 1;

	localparam int NUM_CATEGORIES_DEF = 4;
	localparam int RANDOM_BITS_DEF    = 16;

	localparam logic [WIN_W-1:0] WINDOW_MIN_RST = 10'd7;
	localparam logic [WIN_W-1:0] WINDOW_MAX_RST = 10'd31;

	// item function codes
	localparam logic [FUNC_W-1:0] FUNC_TRIGGER = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_RESULT  = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_INIT    = 2'd2;

	// configuration register indexes
	localparam logic REG_WINDOW_MIN = 1'b0;
	localparam logic REG_WINDOW_MAX = 1'b1;

	// controller to datapath commands
	typedef struct packed {
		logic load;
		logic prep;
		logic step;
		logic commit;
	} orab_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic need_draw;
		logic draw_last;
	} orab_status_t;

endpackage

FILE: hw/rtl/orab_mod.sv
// Iterative remainder unit: one dividend bit per cycle while step is high, restoring form.
module orab_mod
	import orab_pkg::*;
#(
	parameter int RANDOM_BITS = RANDOM_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic                   step,
	input  logic [RANDOM_BITS-1:0] dividend,
	input  logic [REM_W-1:0]       divisor,
	output logic [REM_W-1:0]       rem,
	output logic                   last
);

	localparam int CNT_W = $clog2(RANDOM_BITS);

	logic [RANDOM_BITS-1:0] dvd_q;
	logic [REM_W-1:0]       div_q;
	logic [REM_W-1:0]       rem_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [REM_W-1:0]       shifted;
	logic [REM_W-1:0]       rem_nxt;

	// shift in the next dividend bit and subtract when it fits
	always_comb begin
		shifted = {rem_q[REM_W-2:0], dvd_q[RANDOM_BITS-1]};
		if (shifted >= div_q) begin
			rem_nxt = shifted - div_q;
		end else begin
			rem_nxt = shifted;
		end
	end

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= '0;
		end else if (step) begin
			cnt_q <= cnt_q + CNT_W'(1);
		end
	end

	// operand and remainder registers
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			div_q <= divisor;
			rem_q <= '0;
		end else if (step) begin
			dvd_q <= {dvd_q[RANDOM_BITS-2:0], 1'b0};
			rem_q <= rem_nxt;
		end
	end

	assign rem  = rem_q;
	assign last = (cnt_q == CNT_W'(RANDOM_BITS - 1));

endmodule

FILE: hw/rtl/orab_dp.sv
// Datapath: configuration, per-category state, item decode, draw and result register.
module orab_dp
	import orab_pkg::*;
#(
	parameter int NUM_CATEGORIES = NUM_CATEGORIES_DEF,
	parameter int RANDOM_BITS    = RANDOM_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  orab_cmd_t              cmd,
	output orab_status_t           status,
	input  logic                   cfg_we,
	input  logic                   cfg_index,
	input  logic [WIN_W-1:0]       cfg_data,
	input  logic [FUNC_W-1:0]      func,
	input  logic [CAT_W-1:0]       access_category,
	input  logic [UNIT_W-1:0]      unit_count,
	input  logic                   success,
	input  logic [RANDOM_BITS-1:0] random_value,
	output logic                   attempt,
	output logic [UNIT_W-1:0]      chosen_unit,
	output logic [WIN_W-1:0]       window_now,
	output logic [WIN_W-1:0]       backoff_now
);

	logic [WIN_W-1:0] window_min_q;
	logic [WIN_W-1:0] window_max_q;
	logic [WIN_W-1:0] windows_q  [NUM_CATEGORIES];
	logic [WIN_W-1:0] backoffs_q [NUM_CATEGORIES];

	// latched item
	logic [FUNC_W-1:0]      func_q;
	logic [CAT_W-1:0]       cat_q;
	logic [UNIT_W-1:0]      n_q;
	logic                   ok_q;
	logic [RANDOM_BITS-1:0] r_q;

	// decoded item
	logic             wr_q;
	logic [WIN_W-1:0] res_w_q;
	logic [WIN_W-1:0] res_b_q;
	logic             res_att_q;
	logic             draw_unit_q;
	logic             draw_backoff_q;

	// output payload
	logic              att_q;
	logic [UNIT_W-1:0] unit_q;
	logic [WIN_W-1:0]  win_out_q;
	logic [WIN_W-1:0]  bo_out_q;

	logic             cat_ok;
	logic [WIN_W-1:0] w_cur;
	logic [WIN_W-1:0] b_cur;
	logic [REM_W-1:0] dbl;
	logic             p_wr;
	logic [WIN_W-1:0] p_w;
	logic [WIN_W-1:0] p_b;
	logic             p_att;
	logic             p_draw_unit;
	logic             p_draw_backoff;
	logic [REM_W-1:0] p_divisor;
	logic [REM_W-1:0] rem;
	logic             draw_last;
	logic [WIN_W-1:0] fin_b;
	logic [UNIT_W-1:0] fin_unit;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_min_q <= WINDOW_MIN_RST;
			window_max_q <= WINDOW_MAX_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_WINDOW_MIN: window_min_q <= cfg_data;
				REG_WINDOW_MAX: window_max_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// capture the accepted item
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q <= func;
			cat_q  <= access_category;
			n_q    <= unit_count;
			ok_q   <= success;
			r_q    <= random_value;
		end
	end

	// select the category state
	always_comb begin
		cat_ok = (32'(cat_q) < NUM_CATEGORIES);
		w_cur  = '0;
		b_cur  = '0;
		for (int i = 0; i < NUM_CATEGORIES; i++) begin
			if (32'(cat_q) == i) begin
				w_cur = windows_q[i];
				b_cur = backoffs_q[i];
			end
		end
	end

	// decode the item against the category state
	always_comb begin
		dbl            = {w_cur, 1'b1};
		p_wr           = 1'b0;
		p_w            = w_cur;
		p_b            = b_cur;
		p_att          = 1'b0;
		p_draw_unit    = 1'b0;
		p_draw_backoff = 1'b0;
		p_divisor      = REM_W'(n_q);
		if (!cat_ok) begin
			p_w = '0;
			p_b = '0;
		end else begin
			unique case (func_q)
				FUNC_TRIGGER: begin
					if (n_q != '0) begin
						p_wr = 1'b1;
						if (b_cur > WIN_W'(n_q)) begin
							p_b = b_cur - WIN_W'(n_q);
						end else begin
							p_b         = '0;
							p_att       = 1'b1;
							p_draw_unit = 1'b1;
						end
					end
				end
				FUNC_RESULT, FUNC_INIT: begin
					p_wr           = 1'b1;
					p_draw_backoff = 1'b1;
					if (func_q == FUNC_INIT || ok_q) begin
						p_w = window_min_q;
					end else if (dbl < REM_W'(window_max_q)) begin
						p_w = dbl[WIN_W-1:0];
					end else begin
						p_w = window_max_q;
					end
					p_divisor = REM_W'(p_w) + REM_W'(1);
				end
				default: ;
			endcase
		end
	end

	// hold the decoded item for the draw
	always_ff @(posedge clk) begin
		if (cmd.prep) begin
			wr_q           <= p_wr;
			res_w_q        <= p_w;
			res_b_q        <= p_b;
			res_att_q      <= p_att;
			draw_unit_q    <= p_draw_unit;
			draw_backoff_q <= p_draw_backoff;
		end
	end

	orab_mod #(
		.RANDOM_BITS(RANDOM_BITS)
	) u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.prep),
		.step     (cmd.step),
		.dividend (r_q),
		.divisor  (p_divisor),
		.rem      (rem),
		.last     (draw_last)
	);

	assign status = '{need_draw: p_draw_unit | p_draw_backoff, draw_last: draw_last};

	// merge the remainder into the result
	assign fin_b    = draw_backoff_q ? rem[WIN_W-1:0] : res_b_q;
	assign fin_unit = draw_unit_q ? rem[UNIT_W-1:0] : '0;

	// write back the category state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CATEGORIES; i++) begin
				windows_q[i]  <= WINDOW_MIN_RST;
				backoffs_q[i] <= '0;
			end
		end else if (cmd.commit && wr_q) begin
			for (int i = 0; i < NUM_CATEGORIES; i++) begin
				if (32'(cat_q) == i) begin
					windows_q[i]  <= res_w_q;
					backoffs_q[i] <= fin_b;
				end
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			att_q     <= res_att_q;
			unit_q    <= fin_unit;
			win_out_q <= res_w_q;
			bo_out_q  <= fin_b;
		end
	end

	assign attempt     = att_q;
	assign chosen_unit = unit_q;
	assign window_now  = win_out_q;
	assign backoff_now = bo_out_q;

endmodule

FILE: hw/rtl/orab_ctrl.sv
// Controller: sequences accept, decode, draw and result hand-off for one item at a time.
module orab_ctrl
	import orab_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_stall,
	output logic         out_valid,
	input  logic         out_stall,
	input  orab_status_t status,
	output orab_cmd_t    cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PREP,
		ST_DRAW,
		ST_DONE
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;
	logic   accept;

	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && (state_q == ST_IDLE);

	// commands from the current state
	always_comb begin
		cmd.load   = accept;
		cmd.prep   = (state_q == ST_PREP);
		cmd.step   = (state_q == ST_DRAW);
		cmd.commit = (state_q == ST_DONE) && out_free;
	end

	// state and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_PREP;
					end
				end
				ST_PREP: begin
					state_q <= status.need_draw ? ST_DRAW : ST_DONE;
				end
				ST_DRAW: begin
					if (status.draw_last) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;

endmodule

FILE: hw/rtl/ofdma_random_access_backoff_unit.sv
// Top level of the OFDMA random-access backoff unit.
// Each item is captured on accept, decoded in ST_PREP, drawn in ST_DRAW when it needs a draw,
// and committed in ST_DONE once the output register is free. Items are handled one at a time;
// the bit-serial remainder unit takes one dividend bit per cycle during a draw.
// A finished result waits in the output register while the next item is taken in.
// Reset: windows 7, backoffs 0, window_min 7, window_max 31; no clearing pass.
module ofdma_random_access_backoff_unit
	import orab_pkg::*;
#(
	parameter int NUM_CATEGORIES = NUM_CATEGORIES_DEF,
	parameter int RANDOM_BITS    = RANDOM_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic                   cfg_index,
	input  logic [WIN_W-1:0]       cfg_data,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [FUNC_W-1:0]      func,
	input  logic [CAT_W-1:0]       access_category,
	input  logic [UNIT_W-1:0]      unit_count,
	input  logic                   success,
	input  logic [RANDOM_BITS-1:0] random_value,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic                   attempt,
	output logic [UNIT_W-1:0]      chosen_unit,
	output logic [WIN_W-1:0]       window_now,
	output logic [WIN_W-1:0]       backoff_now
);

	orab_cmd_t    cmd;
	orab_status_t status;

	orab_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	orab_dp #(
		.NUM_CATEGORIES (NUM_CATEGORIES),
		.RANDOM_BITS    (RANDOM_BITS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.status          (status),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.func            (func),
		.access_category (access_category),
		.unit_count      (unit_count),
		.success         (success),
		.random_value    (random_value),
		.attempt         (attempt),
		.chosen_unit     (chosen_unit),
		.window_now      (window_now),
		.backoff_now     (backoff_now)
	);

	// an accepted item keeps the input side busy in the cycle after the accept
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken again right after an accept");

	// a drawn or reduced backoff never exceeds the window
	a_backoff_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> backoff_now <= window_now)
		else $error("backoff above contention window");

	// an attempt leaves the backoff at zero
	a_attempt_zero_backoff: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && attempt |-> backoff_now == '0)
		else $error("attempt with nonzero backoff");

	// a unit is reported only with an attempt
	a_unit_needs_attempt: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !attempt |-> chosen_unit == '0)
		else $error("unit reported without attempt");

endmodule

FILE: tb/sv/ofdma_random_access_backoff_checker.sv
// Checker for the OFDMA random-access backoff unit: predicts each result and compares it.
`timescale 1ns / 1ps

module ofdma_random_access_backoff_checker
	import orab_pkg::*;
#(
	parameter int NUM_CATEGORIES = NUM_CATEGORIES_DEF,
	parameter int RANDOM_BITS    = RANDOM_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic                   cfg_index,
	input  logic [WIN_W-1:0]       cfg_data,
	input  logic                   in_valid,
	input  logic                   in_stall,
	input  logic [FUNC_W-1:0]      func,
	input  logic [CAT_W-1:0]       access_category,
	input  logic [UNIT_W-1:0]      unit_count,
	input  logic                   success,
	input  logic [RANDOM_BITS-1:0] random_value,
	input  logic                   out_valid,
	input  logic                   out_stall,
	input  logic                   attempt,
	input  logic [UNIT_W-1:0]      chosen_unit,
	input  logic [WIN_W-1:0]       window_now,
	input  logic [WIN_W-1:0]       backoff_now,
	output int                     mismatches,
	output int                     results_due
);

	typedef struct packed {
		logic              attempt;
		logic [UNIT_W-1:0] unit;
		logic [WIN_W-1:0]  window;
		logic [WIN_W-1:0]  backoff;
	} backoff_result_t;

	logic [WIN_W-1:0] win_min;
	logic [WIN_W-1:0] win_max;
	logic [WIN_W-1:0] windows [NUM_CATEGORIES];
	logic [WIN_W-1:0] backoffs [NUM_CATEGORIES];
	backoff_result_t  pending_results [$];
	int               errors;

	// Work out the result of one item and advance the category's window and backoff.
	function automatic backoff_result_t predict_backoff(
		input logic [FUNC_W-1:0]      fn,
		input logic [CAT_W-1:0]       cat,
		input logic [UNIT_W-1:0]      n,
		input logic                   ok,
		input logic [RANDOM_BITS-1:0] r
	);
		backoff_result_t  res;
		logic [WIN_W:0]   doubled;
		logic [WIN_W-1:0] w;
		logic [WIN_W-1:0] b;
		res = '0;
		if (int'(cat) >= NUM_CATEGORIES)
			return res;
		w = windows[cat];
		b = backoffs[cat];
		case (fn)
			FUNC_TRIGGER: begin
				// zero units leave everything alone
				if (n != '0) begin
					if (b > WIN_W'(n)) begin
						b = b - WIN_W'(n);
					end else begin
						b = '0;
						res.attempt = 1'b1;
						res.unit = UNIT_W'(longint'(r) % longint'(n));
					end
				end
			end
			FUNC_RESULT, FUNC_INIT: begin
				if (fn == FUNC_INIT || ok) begin
					w = win_min;
				end else begin
					// double plus one, capped at window_max even below window_min
					doubled = {w, 1'b1};
					w = (doubled < {1'b0, win_max}) ? doubled[WIN_W-1:0] : win_max;
				end
				b = WIN_W'(longint'(r) % (longint'(w) + 1));
			end
			default: ;
		endcase
		windows[cat] = w;
		backoffs[cat] = b;
		res.window = w;
		res.backoff = b;
		return res;
	endfunction

	task automatic check_field(input string name, input int unsigned want, input int unsigned got);
		if (want != got) begin
			errors++;
			$display("%0t: %s expected %0d actual %0d", $time, name, want, got);
		end
	endtask

	// Track configuration, compare results in order, queue predictions for accepted items.
	always @(posedge clk or negedge arst_n) begin
		backoff_result_t want;
		backoff_result_t predicted;
		if (!arst_n) begin
			win_min = WINDOW_MIN_RST;
			win_max = WINDOW_MAX_RST;
			for (int i = 0; i < NUM_CATEGORIES; i++) begin
				windows[i] = WINDOW_MIN_RST;
				backoffs[i] = '0;
			end
			pending_results.delete();
			errors = 0;
			mismatches <= 0;
			results_due <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_WINDOW_MIN: win_min = cfg_data;
					REG_WINDOW_MAX: win_max = cfg_data;
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				if (pending_results.size() == 0) begin
					errors++;
					$display("%0t: result with no item waiting: attempt %0d unit %0d window %0d backoff %0d",
						$time, attempt, chosen_unit, window_now, backoff_now);
				end else begin
					want = pending_results.pop_front();
					check_field("attempt", 32'(want.attempt), 32'(attempt));
					check_field("chosen_unit", 32'(want.unit), 32'(chosen_unit));
					check_field("window_now", 32'(want.window), 32'(window_now));
					check_field("backoff_now", 32'(want.backoff), 32'(backoff_now));
				end
			end
			if (in_valid && !in_stall) begin
				predicted = predict_backoff(func, access_category, unit_count, success,
					random_value);
				pending_results = {pending_results, predicted};
			end
			mismatches <= errors;
			results_due <= pending_results.size();
		end
	end

endmodule

FILE: tb/sv/testbench.sv
// Top of the backoff unit testbench: clock, reset, stimulus, receiver stalls and verdict.
`timescale 1ns / 1ps

module testbench;
	import orab_pkg::*;

	localparam logic [FUNC_W-1:0] FUNC_UNKNOWN = 2'd3;
	localparam int RND_W           = RANDOM_BITS_DEF;
	localparam int PHASES          = 6;
	localparam int ITEMS_PER_PHASE = 180;
	localparam int CALM_PHASE      = 2;
	localparam int HOLD_START      = 1000;
	localparam int HOLD_LEN        = 400;
	localparam int RX_CALM_START   = 9000;
	localparam int RX_CALM_LEN     = 2000;
	localparam int CYCLE_LIMIT     = 400000;
	localparam int DRAIN_CYCLES    = 25;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_we = 1'b0;
	logic              cfg_index = 1'b0;
	logic [WIN_W-1:0]  cfg_data = '0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [FUNC_W-1:0] func = FUNC_TRIGGER;
	logic [CAT_W-1:0]  access_category = '0;
	logic [UNIT_W-1:0] unit_count = '0;
	logic              success = 1'b0;
	logic [RND_W-1:0]  random_value = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic              attempt;
	logic [UNIT_W-1:0] chosen_unit;
	logic [WIN_W-1:0]  window_now;
	logic [WIN_W-1:0]  backoff_now;
	int                mismatches;
	int                results_due;
	int unsigned       rx_cycle = 0;
	int unsigned       cycle_count = 0;
	bit                sender_calm = 1'b0;

	ofdma_random_access_backoff_unit i_dut (.*);

	ofdma_random_access_backoff_checker i_checker (.*);

	always #2 clk = ~clk;

	// Give up on a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("ofdma_random_access_backoff_unit: mismatch");
			$finish;
		end
	end

	// Receiver: random stalls, one long hold-off to back the block up, one calm stretch
	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			rx_cycle <= 0;
		end else begin
			rx_cycle <= rx_cycle + 1;
			if (rx_cycle >= HOLD_START && rx_cycle < HOLD_START + HOLD_LEN)
				out_stall <= 1'b1;
			else if (rx_cycle >= RX_CALM_START && rx_cycle < RX_CALM_START + RX_CALM_LEN)
				out_stall <= 1'b0;
			else
				out_stall <= ($urandom_range(99) < 23);
		end
	end

	// Offer one item after a random gap (none while the sender is calm) and hold it until taken
	task automatic drive_item(input logic [FUNC_W-1:0] fn, input logic [CAT_W-1:0] cat,
		input logic [UNIT_W-1:0] n, input logic ok, input logic [RND_W-1:0] r);
		while (!sender_calm && $urandom_range(99) < 23) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		func <= fn;
		access_category <= cat;
		unit_count <= n;
		success <= ok;
		random_value <= r;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	// Mostly triggers with few units so backoffs count down, plus reports, inits and unknown codes
	task automatic random_item();
		int unsigned       pick;
		logic [FUNC_W-1:0] fn;
		logic [UNIT_W-1:0] n;
		logic [RND_W-1:0]  r;
		pick = $urandom_range(99);
		if (pick < 55)
			fn = FUNC_TRIGGER;
		else if (pick < 85)
			fn = FUNC_RESULT;
		else if (pick < 95)
			fn = FUNC_INIT;
		else
			fn = FUNC_UNKNOWN;
		pick = $urandom_range(99);
		if (pick < 70)
			n = UNIT_W'($urandom_range(16, 1));
		else if (pick < 80)
			n = '0;
		else if (pick < 90)
			n = UNIT_W'($urandom_range(127, 17));
		else
			n = '1;
		pick = $urandom_range(99);
		if (pick < 5)
			r = '0;
		else if (pick < 10)
			r = '1;
		else
			r = RND_W'($urandom_range(65535));
		drive_item(fn, CAT_W'($urandom_range(3)), n, 1'($urandom_range(1)), r);
	endtask

	// Drain the block, then write both window registers
	task automatic set_windows(input logic [WIN_W-1:0] lo, input logic [WIN_W-1:0] hi);
		in_valid <= 1'b0;
		do @(posedge clk); while (results_due != 0);
		cfg_we <= 1'b1;
		cfg_index <= REG_WINDOW_MIN;
		cfg_data <= lo;
		@(posedge clk);
		cfg_index <= REG_WINDOW_MAX;
		cfg_data <= hi;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		logic [WIN_W-1:0] lo;
		logic [WIN_W-1:0] hi;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: trigger on a fresh category, zero and maximum units, unknown code
		drive_item(FUNC_TRIGGER, 2'd0, 7'd5, 1'b0, 16'hFFFF);
		drive_item(FUNC_TRIGGER, 2'd1, 7'd0, 1'b1, 16'h1234);
		drive_item(FUNC_TRIGGER, 2'd2, 7'd127, 1'b0, 16'hFFFF);
		drive_item(FUNC_UNKNOWN, 2'd3, 7'd9, 1'b1, 16'hABCD);
		// Init every category with extreme and mid-range draws
		drive_item(FUNC_INIT, 2'd0, 7'd0, 1'b0, 16'h0000);
		drive_item(FUNC_INIT, 2'd1, 7'd127, 1'b1, 16'hFFFF);
		drive_item(FUNC_INIT, 2'd2, 7'd3, 1'b0, 16'h1234);
		drive_item(FUNC_INIT, 2'd3, 7'd64, 1'b1, 16'h8000);
		// Grow the window to its cap, then count the backoff down to an attempt
		drive_item(FUNC_RESULT, 2'd1, 7'd0, 1'b0, 16'hFFFF);
		drive_item(FUNC_RESULT, 2'd1, 7'd0, 1'b0, 16'hFFFF);
		drive_item(FUNC_RESULT, 2'd1, 7'd0, 1'b0, 16'hFFFF);
		drive_item(FUNC_TRIGGER, 2'd1, 7'd1, 1'b0, 16'h0000);
		drive_item(FUNC_TRIGGER, 2'd1, 7'd29, 1'b0, 16'h7FFF);
		drive_item(FUNC_TRIGGER, 2'd1, 7'd1, 1'b0, 16'hFFFF);
		// Success resets the window; backoff equal to units still attempts
		drive_item(FUNC_RESULT, 2'd1, 7'd0, 1'b1, 16'd5);
		drive_item(FUNC_TRIGGER, 2'd1, 7'd5, 1'b1, 16'hFFFF);
		drive_item(FUNC_TRIGGER, 2'd2, 7'd1, 1'b0, 16'h0000);
		drive_item(FUNC_RESULT, 2'd3, 7'd0, 1'b0, 16'h0000);
		drive_item(FUNC_UNKNOWN, 2'd0, 7'd127, 1'b0, 16'hFFFF);

		// Random phases over several window settings, extremes and an inverted pair included
		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: begin lo = WINDOW_MIN_RST; hi = WINDOW_MAX_RST; end
				1: begin lo = '0; hi = '0; end
				2: begin lo = '1; hi = '1; end
				3: begin lo = '0; hi = '1; end
				4: begin lo = '1; hi = '0; end
				default: begin
					lo = WIN_W'($urandom_range(1023));
					hi = WIN_W'($urandom_range(1023, lo));
				end
			endcase
			set_windows(lo, hi);
			sender_calm = (phase == CALM_PHASE);
			for (int i = 0; i < ITEMS_PER_PHASE; i++)
				random_item();
		end

		// Drain and decide
		in_valid <= 1'b0;
		do @(posedge clk); while (results_due != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("ofdma_random_access_backoff_unit: match");
		else
			$display("ofdma_random_access_backoff_unit: mismatch");
		$finish;
	end

endmodule

FILE: ofdma_random_access_backoff_unit.f
hw/rtl/orab_pkg.sv
hw/rtl/orab_mod.sv
hw/rtl/orab_dp.sv
hw/rtl/orab_ctrl.sv
hw/rtl/ofdma_random_access_backoff_unit.sv
tb/sv/ofdma_random_access_backoff_checker.sv
tb/sv/testbench.sv
